// ----- hdl/clws_pkg.sv -----
`default_nettype none

package clws_pkg;

	localparam int NUM_W      = 32;
	localparam int DIGIT_W    = 4;
	localparam int MAX_DIGITS = 10;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;

	// request codes
	localparam logic [2:0] ACT_CMD    = 3'd0;
	localparam logic [2:0] ACT_DATA   = 3'd1;
	localparam logic [2:0] ACT_INIT   = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_MOVE   = 3'd4;
	localparam logic [2:0] ACT_NUMBER = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_COLUMN = 2'd1;
	localparam logic [1:0] ST_ROW    = 2'd2;

	// register indexes
	localparam logic REG_BUS_MODE    = 1'b0;
	localparam logic REG_LAST_COLUMN = 1'b1;

	localparam logic       BUS_MODE_RESET    = 1'b1;
	localparam logic [5:0] LAST_COLUMN_RESET = 6'd15;

	// lcd command bytes and characters
	localparam logic [7:0] CMD_FUNC_SET  = 8'h38;
	localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
	localparam logic [7:0] CMD_CLEAR     = 8'h01;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
	localparam logic [7:0] ROW1_OFFSET   = 8'h40;
	localparam logic [7:0] NIB_FUNC_HI   = 8'h02;
	localparam logic [7:0] NIB_FUNC_LO   = 8'h08;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_MINUS    = 8'h2D;

	typedef struct packed {
		logic [2:0]        action;
		logic [7:0]        byte_value;
		logic [7:0]        column;
		logic [7:0]        row;
		logic signed [31:0] number;
	} req_t;

	typedef struct packed {
		logic       strobe_res;
		logic       reg_select;
		logic [7:0] bus_value;
		logic [1:0] status;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic start;
		logic shift_digit;
	} bcd_cmd_t;

	typedef struct packed {
		logic               busy;
		logic [DIGIT_W-1:0] digit;
	} bcd_stat_t;

	// one byte unit: single means one transfer even on the nibble bus
	typedef struct packed {
		logic [7:0] value;
		logic       single;
		logic       fin;
	} unit_t;

	function automatic unit_t init_unit(input logic four_bit, input logic [2:0] idx);
		unit_t u;
		u = '{value: CMD_CLEAR, single: 1'b0, fin: 1'b1};
		if (four_bit) begin
			case (idx)
				3'd0: u = '{value: NIB_FUNC_HI, single: 1'b1, fin: 1'b0};
				3'd1: u = '{value: NIB_FUNC_HI, single: 1'b1, fin: 1'b0};
				3'd2: u = '{value: NIB_FUNC_LO, single: 1'b1, fin: 1'b0};
				3'd3: u = '{value: CMD_DISP_ON, single: 1'b0, fin: 1'b0};
				default: u = '{value: CMD_CLEAR, single: 1'b0, fin: 1'b1};
			endcase
		end else begin
			case (idx)
				3'd0: u = '{value: CMD_FUNC_SET, single: 1'b0, fin: 1'b0};
				3'd1: u = '{value: CMD_DISP_ON, single: 1'b0, fin: 1'b0};
				default: u = '{value: CMD_CLEAR, single: 1'b0, fin: 1'b1};
			endcase
		end
		return u;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/clws_bcd.sv -----
`default_nettype none

module clws_bcd import clws_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bcd_cmd_t         cmd,
	input  wire logic [NUM_W-1:0] mag,
	output bcd_stat_t             stat
);

	localparam int BCD_W     = MAX_DIGITS * DIGIT_W;
	localparam int BIT_CNT_W = $clog2(NUM_W + 1);

	logic [BCD_W-1:0]     bcd_q;
	logic [NUM_W-1:0]     bin_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;
	logic [BCD_W-1:0]     adj;

	// add 3 to every digit of 5 or more before the next doubling
	always_comb begin
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
			else
				adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
		end else if (cmd.start) begin
			bit_cnt_q <= BIT_CNT_W'(NUM_W);
		end else if (bit_cnt_q != '0) begin
			bit_cnt_q <= bit_cnt_q - BIT_CNT_W'(1);
		end
	end

	// one magnitude bit per cycle in, one digit per shift out (msd first)
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bcd_q <= '0;
			bin_q <= mag;
		end else if (bit_cnt_q != '0) begin
			bcd_q <= {adj[BCD_W-2:0], bin_q[NUM_W-1]};
			bin_q <= {bin_q[NUM_W-2:0], 1'b0};
		end else if (cmd.shift_digit) begin
			bcd_q <= {bcd_q[BCD_W-DIGIT_W-1:0], DIGIT_W'(0)};
		end
	end

	assign stat.busy  = (bit_cnt_q != '0);
	assign stat.digit = bcd_q[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

// ----- hdl/clws_seq.sv -----
`default_nettype none

module clws_seq import clws_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       bus_mode,
	input  wire logic [5:0] last_column,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp
);

	typedef enum logic [1:0] {S_IDLE, S_CONV, S_SKIP, S_SEND} state_t;
	typedef enum logic [1:0] {K_SINGLE, K_INIT, K_NUMBER} kind_t;

	state_t           state_q;
	kind_t            kind_q;
	logic [7:0]       val_q;
	logic             single_q;
	logic             fin_q;
	logic             nib_q;
	logic             rs_q;
	logic             strobe_q;
	logic [1:0]       status_q;
	logic             neg_q;
	logic [2:0]       init_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;

	bcd_cmd_t         cmd;
	bcd_stat_t        stat;
	logic [NUM_W-1:0] num_u;
	logic [NUM_W-1:0] mag;
	logic             accept;
	logic             out_free;
	logic             split;
	logic             xfer;
	logic             unit_done;
	logic             skip_shift;
	logic             load_digit;
	logic             column_ok;
	logic [7:0]       move_addr;
	logic [1:0]       move_st;
	logic [7:0]       xfer_val;
	unit_t            first_init;
	unit_t            next_init;
	state_t           acc_state;
	kind_t            acc_kind;
	logic [7:0]       acc_val;
	logic             acc_rs;
	logic             acc_strobe;
	logic [1:0]       acc_status;
	logic             acc_single;
	logic             acc_fin;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign split     = bus_mode && !single_q;
	assign xfer      = (state_q == S_SEND) && out_free;
	assign unit_done = xfer && (!split || nib_q);

	// drop leading zero digits but always keep the last one
	assign skip_shift = (state_q == S_SKIP) && (stat.digit == '0) && (cnt_q > CNT_W'(1));
	assign load_digit = ((state_q == S_SKIP) && !skip_shift && !neg_q)
		|| (unit_done && !fin_q && (kind_q == K_NUMBER));

	assign num_u = NUM_W'($unsigned(req.number));
	assign mag   = num_u[NUM_W-1] ? (~num_u + NUM_W'(1)) : num_u;

	assign cmd.start       = accept && (req.action == ACT_NUMBER);
	assign cmd.shift_digit = skip_shift || load_digit;

	assign column_ok  = (req.column <= {2'b00, last_column});
	assign first_init = init_unit(bus_mode, 3'd0);
	assign next_init  = init_unit(bus_mode, init_idx_q + 3'd1);

	always_comb begin
		move_addr = 8'h00;
		move_st   = ST_OK;
		if (req.row == 8'd0)
			move_addr = req.column;
		else if (req.row == 8'd1)
			move_addr = req.column + ROW1_OFFSET;
		else
			move_st = ST_ROW;
	end

	// first unit of a newly accepted request
	always_comb begin
		acc_state  = S_SEND;
		acc_kind   = K_SINGLE;
		acc_val    = req.byte_value;
		acc_rs     = 1'b0;
		acc_strobe = 1'b1;
		acc_status = ST_OK;
		acc_single = 1'b0;
		acc_fin    = 1'b1;
		case (req.action)
			ACT_CMD: acc_val = req.byte_value;
			ACT_DATA: acc_rs = 1'b1;
			ACT_INIT: begin
				acc_kind   = K_INIT;
				acc_val    = first_init.value;
				acc_single = first_init.single;
				acc_fin    = first_init.fin;
			end
			ACT_CLEAR: acc_val = CMD_CLEAR;
			ACT_MOVE: begin
				if (!column_ok) begin
					acc_strobe = 1'b0;
					acc_val    = 8'h00;
					acc_single = 1'b1;
					acc_status = ST_COLUMN;
				end else begin
					acc_val    = move_addr | CMD_SET_DDRAM;
					acc_status = move_st;
				end
			end
			ACT_NUMBER: begin
				acc_kind  = K_NUMBER;
				acc_rs    = 1'b1;
				acc_state = S_CONV;
			end
			default: acc_state = S_IDLE;
		endcase
	end

	always_comb begin
		if (split && !nib_q)
			xfer_val = {4'b0000, val_q[7:4]};
		else if (split)
			xfer_val = {4'b0000, val_q[3:0]};
		else
			xfer_val = val_q;
	end

	clws_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mag    (mag),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= K_SINGLE;
			val_q       <= 8'h00;
			single_q    <= 1'b0;
			fin_q       <= 1'b0;
			nib_q       <= 1'b0;
			rs_q        <= 1'b0;
			strobe_q    <= 1'b0;
			status_q    <= ST_OK;
			neg_q       <= 1'b0;
			init_idx_q  <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (xfer)
				rsp_valid_q <= 1'b1;
			else if (out_free)
				rsp_valid_q <= 1'b0;
			if (load_digit) begin
				val_q    <= CHAR_ZERO | {4'b0000, stat.digit};
				single_q <= 1'b0;
				fin_q    <= (cnt_q == CNT_W'(1));
				cnt_q    <= cnt_q - CNT_W'(1);
			end
			if (skip_shift)
				cnt_q <= cnt_q - CNT_W'(1);

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q    <= acc_state;
						kind_q     <= acc_kind;
						val_q      <= acc_val;
						rs_q       <= acc_rs;
						strobe_q   <= acc_strobe;
						status_q   <= acc_status;
						single_q   <= acc_single;
						fin_q      <= acc_fin;
						nib_q      <= 1'b0;
						init_idx_q <= '0;
						neg_q      <= (req.action == ACT_NUMBER) && num_u[NUM_W-1];
						cnt_q      <= CNT_W'(MAX_DIGITS);
					end
				end
				S_CONV: begin
					if (!stat.busy)
						state_q <= S_SKIP;
				end
				S_SKIP: begin
					if (!skip_shift) begin
						state_q <= S_SEND;
						nib_q   <= 1'b0;
						if (neg_q) begin
							val_q    <= CHAR_MINUS;
							single_q <= 1'b0;
							fin_q    <= 1'b0;
							neg_q    <= 1'b0;
						end
					end
				end
				S_SEND: begin
					if (xfer) begin
						rsp_q <= '{strobe_res: strobe_q, reg_select: rs_q,
							bus_value: xfer_val, status: status_q,
							last: unit_done && fin_q};
						nib_q <= split && !nib_q;
						if (unit_done) begin
							if (fin_q) begin
								state_q <= S_IDLE;
							end else if (kind_q == K_INIT) begin
								init_idx_q <= init_idx_q + 3'd1;
								val_q      <= next_init.value;
								single_q   <= next_init.single;
								fin_q      <= next_init.fin;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// ----- hdl/char_lcd_write_sequencer.sv -----
// a request is taken in the idle state; its first transfer is registered when the output is free
// a number request first runs binary-to-decimal shifting, then skips up to 9 leading zero digits
// throughput: one transfer per cycle while sending with rsp_ready high; the next request is taken
// once the final transfer of the current one is loaded into the output register
// reset: asynchronous, clears the sequencer, the output valid and sets bus_mode 1, last_column 15
`default_nettype none

module char_lcd_write_sequencer import clws_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire req_t              req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output rsp_t                   rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic       bus_mode_q;
	logic [5:0] last_column_q;
	logic       reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q    <= BUS_MODE_RESET;
			last_column_q <= LAST_COLUMN_RESET;
		end else if (reg_wr) begin
			case (paddr[2])
				REG_BUS_MODE: bus_mode_q <= pwdata[0];
				REG_LAST_COLUMN: last_column_q <= pwdata[5:0];
				default: bus_mode_q <= bus_mode_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_BUS_MODE: prdata = {{(DATA_W-1){1'b0}}, bus_mode_q};
			REG_LAST_COLUMN: prdata = {{(DATA_W-6){1'b0}}, last_column_q};
			default: prdata = '0;
		endcase
	end

	clws_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.bus_mode    (bus_mode_q),
		.last_column (last_column_q),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp)
	);

	// a transaction without strobe only reports a rejected column and ends the request
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.strobe_res |-> rsp.last && (rsp.status == ST_COLUMN))
		else $error("status-only transaction malformed");

	// character data never carries an error status
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.reg_select |-> rsp.status == ST_OK)
		else $error("data transaction with error status");

	// nibble bus keeps the upper lines clear
	a_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.strobe_res && bus_mode_q |-> rsp.bus_value[7:4] == 4'h0)
		else $error("nibble transfer with upper bits set");

	// a number request holds off the next one while it converts
	a_number_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.action == ACT_NUMBER) |=> !req_ready)
		else $error("request taken during conversion");

endmodule

`default_nettype wire
